// ===== sv/bmpd_pkg.sv =====
// Package for the BMP 24-bit to RGB565 stream decoder.
// Holds the parser phase type, result status codes, header field positions
// and the queue entry struct shared by the front, queue and back modules.
`timescale 1ns / 1ps
`default_nettype none
package bmpd_pkg;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_PIXELS = 4'b0100,
		PH_IDLE   = 4'b1000
	} phase_t;

	localparam logic [1:0] ST_PIXEL = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [31:0] POS_MAGIC  = 32'd1;
	localparam logic [31:0] POS_OFFSET = 32'd13;
	localparam logic [31:0] POS_WIDTH  = 32'd21;
	localparam logic [31:0] POS_HEIGHT = 32'd25;
	localparam logic [31:0] POS_PLANES = 32'd27;
	localparam logic [31:0] POS_BPP    = 32'd29;
	localparam logic [31:0] POS_COMP   = 32'd33;
	localparam logic [31:0] HDR_LEN    = 32'd34;

	localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
	localparam logic [15:0] BMP_PLANES = 16'd1;
	localparam logic [15:0] BMP_BPP    = 16'd24;

	localparam int Q_DEPTH = 4;

	// One queue entry: an optional pixel followed by an optional status.
	typedef struct packed {
		logic        pix;
		logic [15:0] color;
		logic [9:0]  column;
		logic [11:0] row;
		logic        stat;
		logic [1:0]  status;
	} res_entry_t;

endpackage
`default_nettype wire

// ===== sv/bmpd_front.sv =====
// Front end of the BMP decoder: accepts file bytes, parses the header,
// skips to pixel data and forms pixel and status requests for the queue.
// Depends on bmpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_front
	import bmpd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_file,
	input  wire logic [12:0] disp_rows,
	input  wire logic        q_full,
	output logic             q_push,
	output res_entry_t       q_data
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int BW = $clog2(3 * MAX_WIDTH + 4);

	phase_t          phase_q, phase_n;
	logic [31:0]     pos_q, pos_n;
	logic [31:0]     offset_q, offset_n;
	logic [CW-1:0]   width_q, width_n;
	logic            wok_q, wok_n;
	logic [31:0]     height_q, height_n;
	logic [31:0]     rowi_q, rowi_n;
	logic [BW-1:0]   bir_q, bir_n;
	logic [BW-1:0]   rlast_q, rlast_n;
	logic [CW-1:0]   col_q, col_n;
	logic [1:0]      sel_q, sel_n;
	logic [31:0]     hw_q, hw_n;
	logic [7:0]      blue_q, blue_n;
	logic [7:0]      green_q, green_n;
	logic [15:0]     top16;
	logic [BW-1:0]   w3;
	logic [15:0]     rgb;
	logic [31:0]     col_ext;
	res_entry_t      ent;
	logic            acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign q_push   = acc && (ent.pix || ent.stat);
	assign q_data   = ent;

	assign w3      = (BW'(width_q) << 1) + BW'(width_q);
	assign rgb     = {data_byte[7:3], green_q[7:2], blue_q[7:3]};
	assign col_ext = 32'(col_q);

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		offset_n = offset_q;
		width_n  = width_q;
		wok_n    = wok_q;
		height_n = height_q;
		rowi_n   = rowi_q;
		bir_n    = bir_q;
		rlast_n  = rlast_q;
		col_n    = col_q;
		sel_n    = sel_q;
		hw_n     = hw_q;
		blue_n   = blue_q;
		green_n  = green_q;
		top16    = hw_q[31:16];
		ent      = '0;
		case (phase_q)
			PH_HEADER: begin
				hw_n  = {data_byte, hw_q[31:8]};
				top16 = hw_n[31:16];
				pos_n = pos_q + 32'd1;
				if (pos_q == POS_MAGIC && top16 != BMP_MAGIC) begin
					phase_n    = PH_IDLE;
					ent.stat   = 1'b1;
					ent.status = ST_BAD;
				end else begin
					if (pos_q == POS_OFFSET) offset_n = hw_n;
					if (pos_q == POS_WIDTH) begin
						width_n = hw_n[CW-1:0];
						wok_n   = (hw_n != 32'd0) && (hw_n <= 32'(MAX_WIDTH));
					end
					if (pos_q == POS_HEIGHT) height_n = hw_n;
					if ((pos_q == POS_PLANES && top16 != BMP_PLANES) ||
						(pos_q == POS_BPP && top16 != BMP_BPP)) begin
						phase_n    = PH_IDLE;
						ent.stat   = 1'b1;
						ent.status = ST_BAD;
					end else if (pos_q == POS_COMP) begin
						if (hw_n != 32'd0 || !wok_q || offset_q < HDR_LEN) begin
							phase_n    = PH_IDLE;
							ent.stat   = 1'b1;
							ent.status = ST_BAD;
						end else if (height_q == 32'd0 || height_q[31]) begin
							phase_n    = PH_IDLE;
							ent.stat   = 1'b1;
							ent.status = ST_DONE;
						end else begin
							rlast_n = ((w3 + BW'(3)) & ~BW'(3)) - BW'(1);
							rowi_n  = height_q - 32'd1;
							bir_n   = '0;
							col_n   = '0;
							sel_n   = 2'd0;
							phase_n = (offset_q == HDR_LEN) ? PH_PIXELS : PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				pos_n = pos_q + 32'd1;
				if (pos_n == offset_q) phase_n = PH_PIXELS;
			end
			PH_PIXELS: begin
				if (col_q < width_q) begin
					case (sel_q)
						2'd0: begin
							blue_n = data_byte;
							sel_n  = 2'd1;
						end
						2'd1: begin
							green_n = data_byte;
							sel_n   = 2'd2;
						end
						default: begin
							sel_n = 2'd0;
							col_n = col_q + CW'(1);
							if (rowi_q < 32'(disp_rows)) begin
								ent.pix    = 1'b1;
								ent.color  = {rgb[7:0], rgb[15:8]};
								ent.column = col_ext[9:0];
								ent.row    = rowi_q[11:0];
							end
						end
					endcase
				end
				if (bir_q == rlast_q) begin
					if (rowi_q == 32'd0) begin
						phase_n    = PH_IDLE;
						ent.stat   = 1'b1;
						ent.status = ST_DONE;
					end else begin
						rowi_n = rowi_q - 32'd1;
						bir_n  = '0;
						col_n  = '0;
						sel_n  = 2'd0;
					end
				end else begin
					bir_n = bir_q + BW'(1);
				end
			end
			default: begin
			end
		endcase
		if (end_of_file) begin
			if (phase_n != PH_IDLE) begin
				ent.stat   = 1'b1;
				ent.status = ST_TRUNC;
			end
			phase_n  = PH_HEADER;
			pos_n    = '0;
			offset_n = '0;
			width_n  = '0;
			wok_n    = 1'b0;
			height_n = '0;
			rowi_n   = '0;
			bir_n    = '0;
			col_n    = '0;
			sel_n    = 2'd0;
			hw_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			offset_q <= '0;
			width_q  <= '0;
			wok_q    <= 1'b0;
			height_q <= '0;
			rowi_q   <= '0;
			bir_q    <= '0;
			rlast_q  <= '0;
			col_q    <= '0;
			sel_q    <= 2'd0;
			hw_q     <= '0;
		end else if (acc) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			offset_q <= offset_n;
			width_q  <= width_n;
			wok_q    <= wok_n;
			height_q <= height_n;
			rowi_q   <= rowi_n;
			bir_q    <= bir_n;
			rlast_q  <= rlast_n;
			col_q    <= col_n;
			sel_q    <= sel_n;
			hw_q     <= hw_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			blue_q  <= blue_n;
			green_q <= green_n;
		end
	end

endmodule
`default_nettype wire

// ===== sv/bmpd_queue.sv =====
// Short request queue between the decoder front end and the output stage.
// Holds res_entry_t requests; depends on bmpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_queue
	import bmpd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  res_entry_t push_data,
	output logic       full,
	input  wire logic  pop,
	output res_entry_t head,
	output logic       empty
);

	localparam int AW = $clog2(Q_DEPTH);
	localparam int CNW = $clog2(Q_DEPTH + 1);

	res_entry_t     mem_q [Q_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CNW-1:0] cnt_q;

	assign full  = (cnt_q == CNW'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(Q_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + CNW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== sv/bmpd_back.sv =====
// Output stage of the BMP decoder: splits each queued request into its pixel
// and status results and drives the registered output channel. Uses bmpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_back
	import bmpd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  res_entry_t  head,
	input  wire logic   empty,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [15:0] pixel_color,
	output logic [9:0]  column,
	output logic [11:0] row,
	output logic [1:0]  status,
	output logic        last
);

	logic        valid_q;
	logic        half_q;
	logic        load;
	logic        take;
	logic        emit_pix;
	logic [15:0] color_q;
	logic [9:0]  col_q;
	logic [11:0] row_q;
	logic [1:0]  status_q;
	logic        last_q;

	assign load     = !valid_q || out_ready;
	assign take     = load && !empty;
	assign emit_pix = head.pix && !half_q;
	assign pop      = take && !(emit_pix && head.stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (take) half_q <= emit_pix && head.stat;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (emit_pix) begin
				color_q  <= head.color;
				col_q    <= head.column;
				row_q    <= head.row;
				status_q <= ST_PIXEL;
				last_q   <= !head.stat;
			end else begin
				color_q  <= '0;
				col_q    <= '0;
				row_q    <= '0;
				status_q <= head.status;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid   = valid_q;
	assign pixel_color = color_q;
	assign column      = col_q;
	assign row         = row_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule
`default_nettype wire

// ===== sv/bmp24_to_rgb565_stream_decoder_unit.sv =====
// Top level of the BMP 24-bit to RGB565 stream decoder.
// Instantiates bmpd_front, bmpd_queue and bmpd_back; uses bmpd_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready): one BMP file byte per request in file
//   order, end_of_file set on the last byte; the parser then restarts.
// - Output channel (out_valid/out_ready): pixel requests (status 0) with
//   byte-swapped RGB565 color, column and display row, and status requests
//   (1 done, 2 bad header, 3 truncated) with zero payload. last marks the
//   final result of an input byte.
// - Config channel (cfg_valid/cfg_ready, always ready): writes the display
//   row count. Write only while the decoder is idle.
// - Throughput: one byte per cycle while the queue is not full. A byte that
//   yields a pixel and a status gives two output results, the pixel first.
// - Result path: with the queue empty, a result is written into the queue when
//   its byte is accepted and is then loaded into the output register.
// - Receiver stall: the output register holds, the four-entry queue fills,
//   and in_ready drops when it is full.
// - Reset: parser returns to the header phase, queue and output empty,
//   the display row count returns to 240.
`timescale 1ns / 1ps
`default_nettype none
module bmp24_to_rgb565_stream_decoder_unit
	import bmpd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      pixel_color,
	output logic [9:0]       column,
	output logic [11:0]      row,
	output logic [1:0]       status,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] cfg_data
);

	logic [12:0] disp_h_q;
	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	res_entry_t  q_in;
	res_entry_t  q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_h_q <= 13'd240;
		end else if (cfg_valid && cfg_ready) begin
			disp_h_q <= cfg_data;
		end
	end

	bmpd_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.end_of_file(end_of_file),
		.disp_rows  (disp_h_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	bmpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	bmpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_color(pixel_color),
		.column     (column),
		.row        (row),
		.status     (status),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== sv/bmpd_checker.sv =====
// Port-level checker for the BMP decoder top level, bound to it below.
// Uses bmpd_pkg status codes.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_checker
	import bmpd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [7:0]  data_byte,
	input wire logic        end_of_file,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] pixel_color,
	input wire logic [9:0]  column,
	input wire logic [11:0] row,
	input wire logic [1:0]  status,
	input wire logic        last
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) &&
		$stable(end_of_file))
		else $error("input request changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color) &&
		$stable(status) && $stable(last))
		else $error("output changed while stalled");

	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_PIXEL |-> pixel_color == 16'd0 &&
		column == 10'd0 && row == 12'd0)
		else $error("status result with nonzero payload");

	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_PIXEL |-> last)
		else $error("status result not marked last");

	a_pix_then_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && status == ST_PIXEL && !last |=>
		out_valid && status != ST_PIXEL)
		else $error("pixel without last not followed by status");

endmodule

bind bmp24_to_rgb565_stream_decoder_unit bmpd_checker u_bmpd_checker (.*);
`default_nettype wire
